@@ design/rspf_pkg.sv @@
// ============================================================================
// RSPF parser package
// Shared item types, parse phases, record kinds and fixed packet offsets.
// ============================================================================
package rspf_pkg;

    // One packet byte as it arrives from the link side.
    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic        first;
        logic [15:0] pkt_length;
    } in_item_t;

    // One decoded record.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [15:0] word;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [7:0]  byte_d;
        logic [7:0]  byte_e;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HEAD = 3'd1,
        PH_TEXT = 3'd2,
        PH_GAP  = 3'd3,
        PH_SEEK = 3'd4,
        PH_NODE = 3'd5,
        PH_LINK = 3'd6,
        PH_ADJ  = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_RRH_HDR  = 3'd0;
    localparam logic [2:0] KIND_RRH_TEXT = 3'd1;
    localparam logic [2:0] KIND_UPD_HDR  = 3'd2;
    localparam logic [2:0] KIND_ROUTER   = 3'd3;
    localparam logic [2:0] KIND_LINK     = 3'd4;
    localparam logic [2:0] KIND_ADJ      = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

    localparam logic [7:0] TYPE_UPDATE = 8'd1;
    localparam logic [7:0] TYPE_RRH    = 8'd3;

    localparam logic [15:0] IDX_VERSION = 16'd0;
    localparam logic [15:0] IDX_TYPE    = 16'd1;
    localparam logic [15:0] IDX_UPD_HDR = 16'd9;
    localparam logic [15:0] IDX_RRH_HDR = 16'd10;

    localparam logic [8:0] SYNC_OFFSET    = 9'd6;
    localparam logic [8:0] NODE_START_MIN = 9'd10;

    // Remaining length must exceed these at the first byte of a record.
    localparam logic [15:0] MIN_REM_NODE  = 16'd7;
    localparam logic [15:0] MIN_REM_SHORT = 16'd4;

    // Position of the final byte within each record.
    localparam logic [2:0] NODE_LAST_POS = 3'd7;
    localparam logic [2:0] LINK_LAST_POS = 3'd3;
    localparam logic [2:0] ADJ_LAST_POS  = 3'd4;

endpackage

@@ design/rspf_in_stage.sv @@
// ============================================================================
// RSPF input register
// Holds one accepted byte until the parse core takes it.
// ============================================================================
module rspf_in_stage
    import rspf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     step,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The register frees up in the same cycle as the core consumes it.
    assign item_stall = valid_reg && !step;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ design/rspf_parse_core.sv @@
// ============================================================================
// RSPF parse core
// Parse state registers and the per-byte decode that advances them.
// ============================================================================
module rspf_parse_core
    import rspf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    logic [15:0] idx_reg,    idx_next;
    logic [15:0] rem_reg,    rem_next;
    logic [7:0]  ver_reg,    ver_next;
    logic [7:0]  typ_reg,    typ_next;
    phase_t      phase_reg,  phase_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [63:0] asm_reg,    asm_next;
    logic [7:0]  nodes_reg,  nodes_next;
    logic [7:0]  links_reg,  links_next;
    logic [7:0]  adjs_reg,   adjs_next;
    logic [8:0]  start_reg,  start_next;

    phase_t      phase_work;
    logic        active;
    logic        start_rec;
    logic [63:0] asm_base;
    logic [7:0]  b;
    logic [8:0]  sync_start;

    always_comb
    begin
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        ver_next   = ver_reg;
        typ_next   = typ_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        asm_next   = asm_reg;
        nodes_next = nodes_reg;
        links_next = links_reg;
        adjs_next  = adjs_reg;
        start_next = start_reg;
        phase_work = phase_reg;
        active     = 1'b0;
        start_rec  = 1'b0;
        asm_base   = asm_reg;
        b          = item.pkt_byte;
        sync_start = 9'd0;
        res_valid  = 1'b0;
        res        = '0;

        if (step)
        begin
            if (item.first)
            begin
                idx_next   = 16'd0;
                rem_next   = item.pkt_length;
                phase_work = PH_HEAD;
                asm_base   = 64'd0;
                pos_next   = 3'd0;
                nodes_next = 8'd0;
                links_next = 8'd0;
                adjs_next  = 8'd0;
                active     = 1'b1;
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (idx_reg != 16'hFFFF)
                begin
                    idx_next = idx_reg + 16'd1;
                end
                if (rem_reg != 16'd0)
                begin
                    rem_next = rem_reg - 16'd1;
                end
                active = 1'b1;
            end
        end

        if (active)
        begin
            asm_next   = {asm_base[55:0], b};
            phase_next = phase_work;
            unique case (phase_work)
                PH_HEAD:
                begin
                    if (idx_next == IDX_VERSION)
                    begin
                        ver_next = b;
                    end
                    else if (idx_next == IDX_TYPE)
                    begin
                        typ_next = b;
                        if (b != TYPE_RRH && b != TYPE_UPDATE)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = KIND_UNKNOWN;
                            res.byte_a = ver_reg;
                            res.byte_b = b;
                        end
                    end
                    else if (typ_reg == TYPE_RRH && idx_next == IDX_RRH_HDR)
                    begin
                        phase_next = PH_TEXT;
                        res_valid  = 1'b1;
                        res.kind   = KIND_RRH_HDR;
                        res.word   = asm_next[23:8];
                        res.byte_a = ver_reg;
                        res.byte_b = b;
                    end
                    else if (typ_reg == TYPE_UPDATE && idx_next == IDX_UPD_HDR)
                    begin
                        sync_start = {1'b0, asm_next[31:24]} + SYNC_OFFSET;
                        if (sync_start < NODE_START_MIN)
                        begin
                            start_next = NODE_START_MIN;
                        end
                        else
                        begin
                            start_next = sync_start;
                        end
                        nodes_next = asm_next[23:16];
                        links_next = 8'd0;
                        adjs_next  = 8'd0;
                        phase_next = PH_GAP;
                        res_valid  = 1'b1;
                        res.kind   = KIND_UPD_HDR;
                        res.word   = asm_next[15:0];
                        res.byte_a = ver_reg;
                        res.byte_b = asm_next[63:56];
                        res.byte_c = asm_next[55:48];
                        res.byte_d = asm_next[31:24];
                        res.byte_e = asm_next[23:16];
                    end
                end
                PH_TEXT:
                begin
                    if (rem_next == 16'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_RRH_TEXT;
                        res.byte_a = b;
                    end
                end
                PH_GAP:
                begin
                    start_rec = (idx_next == {7'd0, start_reg});
                end
                PH_SEEK:
                begin
                    start_rec = 1'b1;
                end
                PH_NODE:
                begin
                    if (pos_reg < NODE_LAST_POS)
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        links_next = b;
                        adjs_next  = 8'd0;
                        phase_next = PH_SEEK;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ROUTER;
                        res.addr   = asm_next[63:32];
                        res.word   = asm_next[31:16];
                        res.byte_a = asm_next[15:8];
                        res.byte_b = b;
                    end
                end
                PH_LINK:
                begin
                    if (pos_reg < LINK_LAST_POS)
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        adjs_next  = b;
                        phase_next = PH_SEEK;
                        res_valid  = 1'b1;
                        res.kind   = KIND_LINK;
                        res.byte_a = asm_next[31:24];
                        res.byte_b = asm_next[23:16];
                        res.byte_c = asm_next[15:8];
                        res.byte_d = b;
                    end
                end
                PH_ADJ:
                begin
                    if (pos_reg < ADJ_LAST_POS)
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_SEEK;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ADJ;
                        res.addr   = asm_next[31:0];
                        res.byte_a = {2'b00, asm_next[37:32]};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Pick the innermost level with records left and check the
            // remaining length against the size of that record.
            if (start_rec)
            begin
                pos_next = 3'd1;
                if (adjs_reg != 8'd0)
                begin
                    adjs_next  = adjs_reg - 8'd1;
                    phase_next = (rem_next > MIN_REM_SHORT) ? PH_ADJ : PH_IDLE;
                end
                else if (links_reg != 8'd0)
                begin
                    links_next = links_reg - 8'd1;
                    phase_next = (rem_next > MIN_REM_SHORT) ? PH_LINK : PH_IDLE;
                end
                else if (nodes_reg != 8'd0)
                begin
                    nodes_next = nodes_reg - 8'd1;
                    phase_next = (rem_next > MIN_REM_NODE) ? PH_NODE : PH_IDLE;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 16'd0;
            rem_reg   <= 16'd0;
            ver_reg   <= 8'd0;
            typ_reg   <= 8'd0;
            phase_reg <= PH_IDLE;
            pos_reg   <= 3'd0;
            asm_reg   <= 64'd0;
            nodes_reg <= 8'd0;
            links_reg <= 8'd0;
            adjs_reg  <= 8'd0;
            start_reg <= 9'd0;
        end
        else
        begin
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            ver_reg   <= ver_next;
            typ_reg   <= typ_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            asm_reg   <= asm_next;
            nodes_reg <= nodes_next;
            links_reg <= links_next;
            adjs_reg  <= adjs_next;
            start_reg <= start_next;
        end
    end

endmodule

@@ design/rspf_out_stage.sv @@
// ============================================================================
// RSPF result register
// Holds one decoded record until the downstream side takes it.
// ============================================================================
module rspf_out_stage
    import rspf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t res,
    output logic      ready,
    output logic      rec_valid,
    input  logic      rec_stall,
    output out_item_t rec
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t rec_reg;

    assign ready = !valid_reg || !rec_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rec_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= res;
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

endmodule

@@ design/rspf_packet_field_parser_top.sv @@
// ============================================================================
// RSPF packet field parser, top level
// Decodes an RSPF packet, one byte per item, into header and routing records.
// ============================================================================
// The block takes one packet byte per cycle while no finished record waits on
// a stalled output: an accepted byte is held in the input register, the parse
// core decodes it against the parse state in a single pass, and any record it
// completes lands in the result register and is presented from there. A byte
// with first set restarts the parse and samples pkt_length; bytes that arrive
// while the parser is idle and first is low are dropped without a record.
// Type 3 packets give a header record at byte ten and then one text record
// per byte up to the packet length; type 1 packets give an update header at
// byte nine and then router, link and adjacency records, each checked
// against the remaining length at its first byte; any other type gives one
// unknown-type record at byte one. The input side is stalled only while a
// finished record waits on a stalled output.
module rspf_packet_field_parser_top
    import rspf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      rec_valid,
    input  logic      rec_stall,
    output out_item_t rec
);

    logic      held_valid;
    in_item_t  held_item;
    logic      out_ready;
    logic      step;
    logic      res_valid;
    out_item_t res;

    // The core advances on a held byte only when the result register can
    // take whatever record that byte produces.
    assign step = held_valid && out_ready;

    rspf_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .step       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rspf_parse_core u_parse_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    rspf_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .ready     (out_ready),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec)
    );

endmodule

@@ design/rspf_checker.sv @@
// ============================================================================
// RSPF parser checker
// Port-level properties of the parser, bound to the top level.
// ============================================================================
module rspf_checker
    import rspf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_item_t  item,
    input logic      rec_valid,
    input logic      rec_stall,
    input out_item_t rec
);

    // A byte held back by the parser stays put on the input side.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input item changed while stalled");

    // A record held back by the downstream side stays put.
    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |=> rec_valid && $stable(rec))
        else $error("record changed while stalled");

    // The input side only backs up behind a stalled record.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> rec_valid && rec_stall)
        else $error("input stalled without a stalled record");

    // Text records carry the character alone.
    a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.kind == KIND_RRH_TEXT |->
            rec.addr == 32'd0 && rec.word == 16'd0 && rec.byte_b == 8'd0
            && rec.byte_c == 8'd0 && rec.byte_d == 8'd0 && rec.byte_e == 8'd0)
        else $error("text record has stray fields");

    // Adjacency prefix length is six bits wide.
    a_adj_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.kind == KIND_ADJ |-> rec.byte_a[7:6] == 2'b00)
        else $error("adjacency prefix length out of range");

endmodule

bind rspf_packet_field_parser_top rspf_checker u_rspf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec        (rec)
);
